// File: sv/selective_repeat_arq_control_top_defines.svh
// Assertion macros shared by the selective-repeat ARQ control RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef SELECTIVE_REPEAT_ARQ_CONTROL_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_ARQ_CONTROL_TOP_DEFINES_SVH

// same-cycle implication
`define SRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sra_pkg.sv
// Types, codes and sequence helpers for the selective-repeat ARQ control core.
// No dependencies; used by every other file of the block but the assertion macro header.
package sra_pkg;

  localparam int unsigned SEQ_W  = 5;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned WINDOW = 1 << SLOT_W;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam seq_t SEQ_MAX    = seq_t'((1 << SEQ_W) - 1);
  localparam seq_t WINDOW_SEQ = seq_t'(WINDOW);

  typedef enum logic [2:0] {
    OP_NET     = 3'd0,
    OP_PHYS    = 3'd1,
    OP_RX      = 3'd2,
    OP_ACK_TO  = 3'd3,
    OP_DATA_TO = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ACT_SEND      = 3'd0,
    ACT_STORE     = 3'd1,
    ACT_DELIVER   = 3'd2,
    ACT_STOP      = 3'd3,
    ACT_START_ACK = 3'd4,
    ACT_FLOW      = 3'd5
  } act_e;

  typedef enum logic [3:0] {
    EVT_NET     = 4'd0,
    EVT_PHYS    = 4'd1,
    EVT_RX_BAD  = 4'd2,
    EVT_RX_DATA = 4'd3,
    EVT_RX_NAK  = 4'd4,
    EVT_RX_ACK  = 4'd5,
    EVT_ACK_TO  = 4'd6,
    EVT_DATA_TO = 4'd7,
    EVT_OTHER   = 4'd8
  } evt_e;

  typedef struct packed {
    evt_e  evt;
    seq_t  seq;
    seq_t  ack;
    slot_t tslot;
  } cmd_t;

  typedef struct packed {
    act_e  action;
    kind_e tx_kind;
    seq_t  tx_seq;
    seq_t  tx_ack;
    slot_t slot;
    logic  net_enable;
    logic  last;
  } act_t;

  function automatic seq_t seq_next(seq_t k);
    return (k == SEQ_MAX) ? '0 : seq_t'(k + 1'b1);
  endfunction

  function automatic seq_t seq_prev(seq_t k);
    return (k == '0) ? SEQ_MAX : seq_t'(k - 1'b1);
  endfunction

  // a <= b < c on the circular sequence space
  function automatic logic in_win(seq_t a, seq_t b, seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  // window is a power of two: slot is the low bits of the sequence number
  function automatic slot_t slot_of(seq_t s);
    return s[SLOT_W-1:0];
  endfunction

endpackage

// File: sv/sra_in_if.sv
// Event channel interface of the ARQ control core: valid/ready plus event fields.
// Depends on sra_pkg.
interface sra_in_if import sra_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        frame_good;
  logic [1:0]  rx_kind;
  seq_t        rx_seq;
  seq_t        rx_ack;
  slot_t       timer_slot;

  modport source (output valid, op, frame_good, rx_kind, rx_seq, rx_ack, timer_slot,
                  input ready);
  modport sink   (input valid, op, frame_good, rx_kind, rx_seq, rx_ack, timer_slot,
                  output ready);
endinterface

// File: sv/sra_out_if.sv
// Action channel interface of the ARQ control core: valid/ready plus action fields.
// Depends on sra_pkg.
interface sra_out_if import sra_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [1:0]  tx_kind;
  seq_t        tx_seq;
  seq_t        tx_ack;
  slot_t       slot;
  logic        net_enable;
  logic        last;

  modport source (output valid, action, tx_kind, tx_seq, tx_ack, slot, net_enable, last,
                  input ready);
  modport sink   (input valid, action, tx_kind, tx_seq, tx_ack, slot, net_enable, last,
                  output ready);
endinterface

// File: sv/sra_front.sv
// Front end: takes event beats and classifies them into queue commands.
// Depends on sra_pkg and sra_in_if.
module sra_front import sra_pkg::*; (
  sra_in_if.sink evt_i,
  output logic   push_valid_o,
  input  logic   push_ready_i,
  output cmd_t   push_cmd_o
);

  evt_e evt;

  always_comb begin
    case (evt_i.op)
      OP_NET:     evt = EVT_NET;
      OP_PHYS:    evt = EVT_PHYS;
      OP_RX: begin
        if (!evt_i.frame_good) begin
          evt = EVT_RX_BAD;
        end else if (evt_i.rx_kind == KIND_DATA) begin
          evt = EVT_RX_DATA;
        end else if (evt_i.rx_kind == KIND_NAK) begin
          evt = EVT_RX_NAK;
        end else begin
          evt = EVT_RX_ACK;
        end
      end
      OP_ACK_TO:  evt = EVT_ACK_TO;
      OP_DATA_TO: evt = EVT_DATA_TO;
      default:    evt = EVT_OTHER;
    endcase
  end

  assign push_cmd_o.evt   = evt;
  assign push_cmd_o.seq   = evt_i.rx_seq;
  assign push_cmd_o.ack   = evt_i.rx_ack;
  assign push_cmd_o.tslot = evt_i.timer_slot;
  assign push_valid_o     = evt_i.valid;
  assign evt_i.ready      = push_ready_i;

endmodule

// File: sv/sra_queue.sv
// Small command queue between front and back ends, flip-flop storage.
// Depends on sra_pkg and the assertion macro header.
`include "selective_repeat_arq_control_top_defines.svh"
module sra_queue import sra_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : PTR_W'(wr_q + 1'b1);
    end
    if (pop) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : PTR_W'(rd_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  `SRA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_FULL, "sra_queue: count above depth")
  `SRA_ASSERT_NXT(a_cnt_up, push && !pop, cnt_q == CNT_W'($past(cnt_q) + 1'b1), "sra_queue: lost push")
  `SRA_ASSERT_NXT(a_ptr_sync, pop && !push, wr_q == $past(wr_q), "sra_queue: write pointer moved")

endmodule

// File: sv/sra_back.sv
// Back end: window state and action sequencer; takes a new event only once the last run is done.
// Depends on sra_pkg, sra_out_if and the assertion macro header.
`include "selective_repeat_arq_control_top_defines.svh"
module sra_back import sra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pop_valid_i,
  output logic     pop_ready_o,
  input  cmd_t     pop_cmd_i,
  sra_out_if.source act_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_HEAD  = 6'b000010,
    ST_STORE = 6'b000100,
    ST_DELIV = 6'b001000,
    ST_ACKW  = 6'b010000,
    ST_FLOW  = 6'b100000
  } state_e;

  state_e            st_q, st_d;
  cmd_t              cmd_q, cmd_d;
  seq_t              sn_q, sn_d, al_q, al_d, rl_q, rl_d, rh_q, rh_d;
  logic [SEQ_W-1:0]  bc_q, bc_d;
  logic              nak_ok_q, nak_ok_d, phys_q, phys_d, dlv_q, dlv_d;
  logic [WINDOW-1:0] marks_q, marks_d;
  logic              ov_q, ov_d;
  act_t              out_q, out_d;
  logic              emit_ok, load;
  seq_t              to_a, to_b, nak_r;
  logic              room;

  assign emit_ok     = !ov_q || act_o.ready;
  assign pop_ready_o = (st_q == ST_IDLE);
  assign room        = (bc_q < SEQ_W'(WINDOW));
  assign to_a        = seq_t'({1'b0, cmd_q.tslot});
  assign to_b        = seq_t'(to_a + WINDOW_SEQ);
  assign nak_r       = seq_next(cmd_q.ack);

  always_comb begin
    st_d     = st_q;
    cmd_d    = cmd_q;
    sn_d     = sn_q;
    al_d     = al_q;
    rl_d     = rl_q;
    rh_d     = rh_q;
    bc_d     = bc_q;
    nak_ok_d = nak_ok_q;
    phys_d   = phys_q;
    dlv_d    = dlv_q;
    marks_d  = marks_q;
    load     = 1'b0;
    out_d    = '0;
    out_d.action  = ACT_FLOW;
    out_d.tx_kind = KIND_DATA;

    case (st_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          cmd_d = pop_cmd_i;
          st_d  = ST_HEAD;
        end
      end
      ST_HEAD: begin
        case (cmd_q.evt)
          EVT_NET: begin
            if (!room) begin
              st_d = ST_FLOW;
            end else if (emit_ok) begin
              load          = 1'b1;
              out_d.action  = ACT_SEND;
              out_d.tx_kind = KIND_DATA;
              out_d.tx_seq  = sn_q;
              out_d.tx_ack  = seq_prev(rl_q);
              out_d.slot    = slot_of(sn_q);
              phys_d        = 1'b0;
              bc_d          = SEQ_W'(bc_q + 1'b1);
              sn_d          = seq_next(sn_q);
              st_d          = ST_FLOW;
            end
          end
          EVT_PHYS: begin
            phys_d = 1'b1;
            st_d   = ST_FLOW;
          end
          EVT_RX_BAD: begin
            if (!nak_ok_q) begin
              st_d = ST_FLOW;
            end else if (emit_ok) begin
              load          = 1'b1;
              out_d.action  = ACT_SEND;
              out_d.tx_kind = KIND_NAK;
              out_d.tx_ack  = seq_prev(rl_q);
              nak_ok_d      = 1'b0;
              phys_d        = 1'b0;
              st_d          = ST_FLOW;
            end
          end
          EVT_ACK_TO: begin
            if (emit_ok) begin
              load          = 1'b1;
              out_d.action  = ACT_SEND;
              out_d.tx_kind = KIND_ACK;
              out_d.tx_ack  = seq_prev(rl_q);
              phys_d        = 1'b0;
              st_d          = ST_FLOW;
            end
          end
          EVT_DATA_TO: begin
            if (!in_win(al_q, to_a, sn_q) && !in_win(al_q, to_b, sn_q)) begin
              st_d = ST_FLOW;
            end else if (emit_ok) begin
              load          = 1'b1;
              out_d.action  = ACT_SEND;
              out_d.tx_kind = KIND_DATA;
              out_d.tx_seq  = in_win(al_q, to_a, sn_q) ? to_a : to_b;
              out_d.tx_ack  = seq_prev(rl_q);
              out_d.slot    = cmd_q.tslot;
              phys_d        = 1'b0;
              st_d          = ST_FLOW;
            end
          end
          EVT_RX_DATA: begin
            if (emit_ok) begin
              load = 1'b1;
              if ((cmd_q.seq != rl_q) && nak_ok_q) begin
                out_d.action  = ACT_SEND;
                out_d.tx_kind = KIND_NAK;
                out_d.tx_ack  = seq_prev(rl_q);
                nak_ok_d      = 1'b0;
                phys_d        = 1'b0;
              end else begin
                out_d.action  = ACT_START_ACK;
              end
              st_d = ST_STORE;
            end
          end
          EVT_RX_NAK: begin
            if (!in_win(al_q, nak_r, sn_q)) begin
              st_d = ST_ACKW;
            end else if (emit_ok) begin
              load          = 1'b1;
              out_d.action  = ACT_SEND;
              out_d.tx_kind = KIND_DATA;
              out_d.tx_seq  = nak_r;
              out_d.tx_ack  = seq_prev(rl_q);
              out_d.slot    = slot_of(nak_r);
              phys_d        = 1'b0;
              st_d          = ST_ACKW;
            end
          end
          EVT_RX_ACK: st_d = ST_ACKW;
          default:    st_d = ST_FLOW;
        endcase
      end
      ST_STORE: begin
        if (!in_win(rl_q, cmd_q.seq, rh_q) || marks_q[slot_of(cmd_q.seq)]) begin
          st_d = ST_ACKW;
        end else if (emit_ok) begin
          load                         = 1'b1;
          out_d.action                 = ACT_STORE;
          out_d.slot                   = slot_of(cmd_q.seq);
          marks_d[slot_of(cmd_q.seq)]  = 1'b1;
          dlv_d                        = 1'b0;
          st_d                         = ST_DELIV;
        end
      end
      ST_DELIV: begin
        if (marks_q[slot_of(rl_q)]) begin
          if (emit_ok) begin
            load                   = 1'b1;
            out_d.action           = ACT_DELIVER;
            out_d.slot             = slot_of(rl_q);
            marks_d[slot_of(rl_q)] = 1'b0;
            nak_ok_d               = 1'b1;
            rl_d                   = seq_next(rl_q);
            rh_d                   = seq_next(rh_q);
            dlv_d                  = 1'b1;
          end
        end else if (!dlv_q) begin
          st_d = ST_ACKW;
        end else if (emit_ok) begin
          load         = 1'b1;
          out_d.action = ACT_START_ACK;
          st_d         = ST_ACKW;
        end
      end
      ST_ACKW: begin
        if (!in_win(al_q, cmd_q.ack, sn_q)) begin
          st_d = ST_FLOW;
        end else if (emit_ok) begin
          load         = 1'b1;
          out_d.action = ACT_STOP;
          out_d.slot   = slot_of(al_q);
          if (bc_q != '0) begin
            bc_d = SEQ_W'(bc_q - 1'b1);
          end
          al_d = seq_next(al_q);
        end
      end
      ST_FLOW: begin
        if (emit_ok) begin
          load             = 1'b1;
          out_d.action     = ACT_FLOW;
          out_d.net_enable = room && phys_q;
          out_d.last       = 1'b1;
          st_d             = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    ov_d = load ? 1'b1 : (act_o.ready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      sn_q     <= '0;
      al_q     <= '0;
      rl_q     <= '0;
      rh_q     <= WINDOW_SEQ;
      bc_q     <= '0;
      nak_ok_q <= 1'b1;
      phys_q   <= 1'b0;
      dlv_q    <= 1'b0;
      marks_q  <= '0;
      ov_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      sn_q     <= sn_d;
      al_q     <= al_d;
      rl_q     <= rl_d;
      rh_q     <= rh_d;
      bc_q     <= bc_d;
      nak_ok_q <= nak_ok_d;
      phys_q   <= phys_d;
      dlv_q    <= dlv_d;
      marks_q  <= marks_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  assign act_o.valid      = ov_q;
  assign act_o.action     = out_q.action;
  assign act_o.tx_kind    = out_q.tx_kind;
  assign act_o.tx_seq     = out_q.tx_seq;
  assign act_o.tx_ack     = out_q.tx_ack;
  assign act_o.slot       = out_q.slot;
  assign act_o.net_enable = out_q.net_enable;
  assign act_o.last       = out_q.last;

  `SRA_ASSERT_IMP(a_bc_bound, 1'b1, bc_q <= SEQ_W'(WINDOW), "sra_back: buffered count above window")
  `SRA_ASSERT_IMP(a_idle_head_clear, st_q == ST_IDLE, !marks_q[slot_of(rl_q)], "sra_back: in-order slot left undelivered")
  `SRA_ASSERT_NXT(a_deliver_step, st_q == ST_DELIV && load && !dlv_d == 1'b0 && marks_q[slot_of(rl_q)], rl_q == seq_next($past(rl_q)), "sra_back: deliver without window advance")
  `SRA_ASSERT_IMP(a_last_flow, load && out_d.last, st_q == ST_FLOW, "sra_back: run closed outside flow control")

endmodule

// File: sv/selective_repeat_arq_control_top.sv
// Top level of the selective-repeat ARQ control core: front end, command queue, back end.
// Depends on sra_pkg, sra_in_if, sra_out_if, sra_front, sra_queue and sra_back.
//
//   channel | dir | interface  | payload
//   evt_i   | in  | sra_in_if  | op, frame_good, rx_kind, rx_seq, rx_ack, timer_slot
//   act_o   | out | sra_out_if | action, tx_kind, tx_seq, tx_ack, slot, net_enable, last
//
// The back end pops an event, then walks its steps (head, store, deliver, ack, flow)
// and emits an action beat for each step that acts; every run ends with a flow beat
// with last set. An ack retires each slot with its own stop beat; a data frame may
// deliver up to 16 slots and retire up to 16. A held beat on act_o stalls the back end.
// Reset clears the window state at once; no clearing pass.
// Up to QUEUE_DEPTH events are taken while the back end works or act_o stalls.
module selective_repeat_arq_control_top import sra_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sra_in_if.sink    evt_i,
  sra_out_if.source act_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  sra_front u_front (
    .evt_i        (evt_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  sra_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  sra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .act_o       (act_o)
  );

endmodule

// File: dv/tb_selective_repeat_arq_control_top.sv
// Testbench for selective_repeat_arq_control_top: drives link events, predicts each action run.
// Depends on sra_pkg, sra_in_if, sra_out_if and the block's RTL.
module tb_selective_repeat_arq_control_top;
  import sra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_RSVD   = 3'd5;
  localparam logic [1:0] KIND_RSVD = 2'd3;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [2:0] op;
    logic       good;
    logic [1:0] kind;
    seq_t       seq;
    seq_t       ack;
    slot_t      tslot;
  } arq_evt_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  sra_in_if  evt_if ();
  sra_out_if act_if ();

  selective_repeat_arq_control_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .act_o  (act_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // link state mirror
  seq_t        snd_next, ack_edge, rcv_lo, rcv_hi;
  int unsigned out_cnt;
  bit          nak_ok, phy_rdy;
  bit          rx_marks [WINDOW];

  act_t        pending_actions [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;

  function automatic bit seq_between(seq_t a, seq_t b, seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic void push_action(act_e a, kind_e k, seq_t s, seq_t ak, slot_t sl,
                                      logic en, logic lst);
    act_t x;
    x.action     = a;
    x.tx_kind    = k;
    x.tx_seq     = s;
    x.tx_ack     = ak;
    x.slot       = sl;
    x.net_enable = en;
    x.last       = lst;
    pending_actions.push_back(x);
  endfunction

  function automatic void reset_link();
    snd_next = '0;
    ack_edge = '0;
    rcv_lo   = '0;
    rcv_hi   = seq_t'(WINDOW);
    out_cnt  = 0;
    nak_ok   = 1'b1;
    phy_rdy  = 1'b0;
    foreach (rx_marks[i]) rx_marks[i] = 1'b0;
  endfunction

  function automatic void tx_frame(kind_e k, seq_t s);
    seq_t  ak;
    slot_t sl;
    ak = seq_t'(rcv_lo - 5'd1);
    sl = (k == KIND_DATA) ? s[SLOT_W-1:0] : '0;
    if (k != KIND_DATA) s = '0;
    if (k == KIND_NAK) nak_ok = 1'b0;
    phy_rdy = 1'b0;
    push_action(ACT_SEND, k, s, ak, sl, 1'b0, 1'b0);
  endfunction

  function automatic void rx_frame(arq_evt_t e);
    slot_t s;
    seq_t  r;
    bit    dlv;
    if (!e.good) begin
      if (nak_ok) tx_frame(KIND_NAK, '0);
      return;
    end
    if (e.kind == KIND_DATA) begin
      s = e.seq[SLOT_W-1:0];
      if (e.seq != rcv_lo && nak_ok) tx_frame(KIND_NAK, '0);
      else push_action(ACT_START_ACK, KIND_DATA, '0, '0, '0, 1'b0, 1'b0);
      if (seq_between(rcv_lo, e.seq, rcv_hi) && !rx_marks[s]) begin
        dlv = 1'b0;
        rx_marks[s] = 1'b1;
        push_action(ACT_STORE, KIND_DATA, '0, '0, s, 1'b0, 1'b0);
        while (rx_marks[rcv_lo[SLOT_W-1:0]]) begin
          push_action(ACT_DELIVER, KIND_DATA, '0, '0, rcv_lo[SLOT_W-1:0], 1'b0, 1'b0);
          nak_ok = 1'b1;
          rx_marks[rcv_lo[SLOT_W-1:0]] = 1'b0;
          rcv_hi = seq_t'(rcv_hi + 5'd1);
          rcv_lo = seq_t'(rcv_lo + 5'd1);
          dlv = 1'b1;
        end
        if (dlv) push_action(ACT_START_ACK, KIND_DATA, '0, '0, '0, 1'b0, 1'b0);
      end
    end
    if (e.kind == KIND_NAK) begin
      r = seq_t'(e.ack + 5'd1);
      if (seq_between(ack_edge, r, snd_next)) tx_frame(KIND_DATA, r);
    end
    while (seq_between(ack_edge, e.ack, snd_next)) begin
      if (out_cnt > 0) out_cnt--;
      push_action(ACT_STOP, KIND_DATA, '0, '0, ack_edge[SLOT_W-1:0], 1'b0, 1'b0);
      ack_edge = seq_t'(ack_edge + 5'd1);
    end
  endfunction

  function automatic void advance_link(arq_evt_t e);
    seq_t a, b;
    if (e.op == OP_NET) begin
      if (out_cnt < WINDOW) begin
        out_cnt++;
        tx_frame(KIND_DATA, snd_next);
        snd_next = seq_t'(snd_next + 5'd1);
      end
    end else if (e.op == OP_PHYS) begin
      phy_rdy = 1'b1;
    end else if (e.op == OP_RX) begin
      rx_frame(e);
    end else if (e.op == OP_ACK_TO) begin
      tx_frame(KIND_ACK, '0);
    end else if (e.op == OP_DATA_TO) begin
      a = {1'b0, e.tslot};
      b = {1'b1, e.tslot};
      if (seq_between(ack_edge, a, snd_next)) tx_frame(KIND_DATA, a);
      else if (seq_between(ack_edge, b, snd_next)) tx_frame(KIND_DATA, b);
    end
    push_action(ACT_FLOW, KIND_DATA, '0, '0, '0, (out_cnt < WINDOW) && phy_rdy, 1'b1);
  endfunction

  function automatic arq_evt_t mk_evt(logic [2:0] op, logic good, logic [1:0] kind,
                                      seq_t seq, seq_t ack, slot_t ts);
    arq_evt_t e;
    e.op = op; e.good = good; e.kind = kind; e.seq = seq; e.ack = ack; e.tslot = ts;
    return e;
  endfunction

  // peer-like event: mostly plausible sequence numbers around both windows
  function automatic arq_evt_t next_event();
    arq_evt_t    e;
    int unsigned r, outstanding;
    r = $urandom_range(0, 99);
    outstanding = int'(seq_t'(snd_next - ack_edge));
    e = mk_evt(3'($urandom_range(0, 7)), 1'($urandom), 2'($urandom), seq_t'($urandom),
               seq_t'($urandom), slot_t'($urandom));
    if (r < 22) begin
      e.op = OP_NET;
    end else if (r < 32) begin
      e.op = OP_PHYS;
    end else if (r < 74) begin
      e.op = OP_RX;
      e.good = 1'b1;
      e.kind = (r < 62) ? KIND_DATA : (($urandom_range(0, 7) == 0) ? KIND_RSVD : KIND_ACK);
      if ($urandom_range(0, 4) != 0) e.seq = seq_t'(rcv_lo + $urandom_range(0, WINDOW - 1));
      if ($urandom_range(0, 4) < 3)
        e.ack = seq_t'(ack_edge - 1 + $urandom_range(0, outstanding));
    end else if (r < 82) begin
      e.op = OP_RX;
      e.good = 1'b1;
      e.kind = KIND_NAK;
      e.ack = seq_t'(ack_edge - 1 + $urandom_range(0, outstanding));
    end else if (r < 88) begin
      e.op = OP_RX;
      e.good = 1'b0;
    end else if (r < 93) begin
      e.op = OP_ACK_TO;
    end else if (r < 98) begin
      e.op = OP_DATA_TO;
      if ($urandom_range(0, 3) != 0)
        e.tslot = slot_t'(ack_edge + $urandom_range(0, outstanding));
    end else begin
      e.op = OP_RSVD + 3'($urandom_range(0, 2));
    end
    return e;
  endfunction

  task automatic send_evt(arq_evt_t e);
    evt_if.valid      <= 1'b1;
    evt_if.op         <= e.op;
    evt_if.frame_good <= e.good;
    evt_if.rx_kind    <= e.kind;
    evt_if.rx_seq     <= e.seq;
    evt_if.rx_ack     <= e.ack;
    evt_if.timer_slot <= e.tslot;
    do @(posedge clk_i); while (!evt_if.ready);
    advance_link(e);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        evt_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic test_directed();
    send_evt(mk_evt(OP_RSVD, 1'b1, KIND_DATA, 5'd31, 5'd31, 4'd15));
    send_evt(mk_evt(OP_RSVD + 3'd2, 1'b0, KIND_RSVD, 5'd0, 5'd0, 4'd0));
    send_evt(mk_evt(OP_PHYS, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0));
    send_evt(mk_evt(OP_NET, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0));
    send_evt(mk_evt(OP_RX, 1'b0, KIND_DATA, 5'd0, 5'd31, 4'd0));
    send_evt(mk_evt(OP_RX, 1'b0, KIND_NAK, 5'd31, 5'd31, 4'd15));
    send_evt(mk_evt(OP_DATA_TO, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd15));
    send_evt(mk_evt(OP_DATA_TO, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0));
    send_evt(mk_evt(OP_ACK_TO, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0));
    send_evt(mk_evt(OP_RX, 1'b1, KIND_DATA, 5'd1, 5'd31, 4'd0));
    send_evt(mk_evt(OP_RX, 1'b1, KIND_DATA, 5'd0, 5'd31, 4'd0));
    send_evt(mk_evt(OP_RX, 1'b1, KIND_DATA, 5'd31, 5'd31, 4'd15));
    send_evt(mk_evt(OP_RX, 1'b1, KIND_NAK, 5'd0, 5'd31, 4'd0));
    send_evt(mk_evt(OP_RX, 1'b1, KIND_RSVD, 5'd0, 5'd0, 4'd0));
    send_evt(mk_evt(OP_RX, 1'b1, KIND_DATA, 5'd2, 5'd31, 4'd0));
    send_evt(mk_evt(OP_RX, 1'b1, KIND_DATA, 5'd2, 5'd31, 4'd0));
  endtask

  // fill the send window, overflow it, then take it back with one cumulative ack
  task automatic test_window_full();
    send_evt(mk_evt(OP_PHYS, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0));
    repeat (WINDOW + 1) send_evt(mk_evt(OP_NET, 1'b1, KIND_DATA, 5'd0, 5'd0, 4'd0));
    send_evt(mk_evt(OP_PHYS, 1'b0, KIND_DATA, 5'd0, 5'd0, 4'd0));
    send_evt(mk_evt(OP_RX, 1'b1, KIND_ACK, 5'd0, seq_t'(snd_next - 5'd1), 4'd0));
    send_evt(mk_evt(OP_NET, 1'b1, KIND_DATA, 5'd0, 5'd0, 4'd0));
  endtask

  task automatic test_pressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_evt(next_event());
    gaps_on  = 1'b1;
  endtask

  task automatic test_random();
    repeat (6) begin
      gaps_on = ($urandom_range(0, 2) != 0);
      repeat (45) send_evt(next_event());
    end
    gaps_on = 1'b1;
  endtask

  // action sink: ready follows a mode picked per stretch, plus one long hold-off on request
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;
  int unsigned hold_left = 0;
  int unsigned sink_phase = 0;

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      act_if.ready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 2));
        sink_left = $urandom_range(20, 120);
      end
      sink_left--;
      sink_phase++;
      case (sink_mode)
        SINK_OPEN:   act_if.ready <= 1'b1;
        SINK_RANDOM: act_if.ready <= ($urandom_range(0, 3) != 0);
        default:     act_if.ready <= ((sink_phase % 7) < 4);
      endcase
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, actual %0d", name, want, seen);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    act_t want;
    if (rst_ni && act_if.valid && act_if.ready) begin
      if (pending_actions.size() == 0) begin
        $error("unexpected beat: action %0d slot %0d last %0d",
               act_if.action, act_if.slot, act_if.last);
        errors++;
      end else begin
        want = pending_actions.pop_front();
        check_field("action", want.action, act_if.action);
        check_field("tx_kind", want.tx_kind, act_if.tx_kind);
        check_field("tx_seq", want.tx_seq, act_if.tx_seq);
        check_field("tx_ack", want.tx_ack, act_if.tx_ack);
        check_field("slot", want.slot, act_if.slot);
        check_field("net_enable", want.net_enable, act_if.net_enable);
        check_field("last", want.last, act_if.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (evt_if.valid && evt_if.ready) || (act_if.valid && act_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    evt_if.valid      = 1'b0;
    evt_if.op         = OP_NET;
    evt_if.frame_good = 1'b0;
    evt_if.rx_kind    = KIND_DATA;
    evt_if.rx_seq     = '0;
    evt_if.rx_ack     = '0;
    evt_if.timer_slot = '0;
    act_if.ready      = 1'b0;
    reset_link();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_window_full();
    test_pressure();
    test_random();
    evt_if.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/sra_pkg.sv
sv/sra_in_if.sv
sv/sra_out_if.sv
sv/sra_front.sv
sv/sra_queue.sv
sv/sra_back.sv
sv/selective_repeat_arq_control_top.sv
dv/tb_selective_repeat_arq_control_top.sv
